// ===== design/slfu_pkg.sv =====
// slfu_pkg: shared codes and constants for the sampled lfu eviction picker
// no dependencies
package slfu_pkg;

  localparam logic [2:0] CMD_ADD    = 3'd0;
  localparam logic [2:0] CMD_ACCESS = 3'd1;
  localparam logic [2:0] CMD_NOTIFY = 3'd2;
  localparam logic [2:0] CMD_FLAGS  = 3'd3;
  localparam logic [2:0] CMD_EVICT  = 3'd4;

  localparam int          SAMPLE_MAX   = 32;
  localparam logic [5:0]  SAMPLE_RESET = 6'd20;
  localparam int          ENTRY_W      = 10;
  localparam int          SCORE_W      = 32;

endpackage

// ===== design/slfu_ram.sv =====
// slfu_ram: generic single-port-write, one-read synchronous ram, registered read
// no dependencies
module slfu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

// ===== design/sampled_lfu_eviction_picker.sv =====
// sampled_lfu_eviction_picker: top level, command sequencer over the entry memories
// depends on slfu_pkg and slfu_ram
//
//  channel  | signals                                                      | dir
//  ---------+--------------------------------------------------------------+----
//  cfg      | cfg_valid cfg_ready cfg_data                                 | in
//  request  | in_valid in_ready cmd entry relevant uptodate on_lru dirty   | in
//           | writeback request_count                                      |
//  result   | out_valid out_ready victim_entry score blocked found last    | out
//
// access and flags read the state word, then write it back; add also writes
// the old tail link in a further state when joining a non-empty list; notify
// reads the links too, with a state for the neighbour link fix-up when listed.
// evict walks the list node by node (S_WRD, S_WCMP: memory read latency in the
// pointer chase), then emits one result per group from the group-best memory.
// after reset a clearing pass sweeps all state memory before requests are taken.
// results wait in an output register; the sequencer stalls on it.
module sampled_lfu_eviction_picker #(
  parameter int ENTRIES     = 1024,
  parameter int MAX_VICTIMS = 32,
  parameter int COUNT_BITS  = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [5:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  cmd,
  input  logic [9:0]  entry,
  input  logic        relevant,
  input  logic        uptodate,
  input  logic        on_lru,
  input  logic        dirty,
  input  logic        writeback,
  input  logic [7:0]  request_count,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [9:0]  victim_entry,
  output logic [31:0] score,
  output logic        blocked,
  output logic        found,
  output logic        last
);

  localparam int AW  = $clog2(ENTRIES);
  localparam int LW  = $clog2(ENTRIES + 1);
  localparam int GW  = (MAX_VICTIMS > 1) ? $clog2(MAX_VICTIMS) : 1;
  localparam int RW  = $clog2(MAX_VICTIMS + 1);
  localparam int NW  = RW + 6;
  localparam int SW  = COUNT_BITS + 3;
  localparam int BW  = AW + COUNT_BITS + 1;
  localparam logic [COUNT_BITS-1:0] CMAX = '1;

  localparam logic [4:0] S_CLEAR = 5'd0;
  localparam logic [4:0] S_IDLE  = 5'd1;
  localparam logic [4:0] S_RD    = 5'd2;
  localparam logic [4:0] S_EXEC  = 5'd3;
  localparam logic [4:0] S_NRD   = 5'd4;
  localparam logic [4:0] S_NFIX  = 5'd6;
  localparam logic [4:0] S_WRD   = 5'd7;
  localparam logic [4:0] S_WCMP  = 5'd8;
  localparam logic [4:0] S_ERD   = 5'd9;
  localparam logic [4:0] S_EOUT  = 5'd10;
  localparam logic [4:0] S_MARK  = 5'd11;
  localparam logic [4:0] S_NWAIT2 = 5'd12;

  logic [4:0] state;
  logic [5:0] samp_size;

  // request latch
  logic [2:0]  r_cmd;
  logic [AW-1:0] r_ent;
  logic        r_flag;

  // list registers
  logic [AW-1:0] head_ptr, list_tail;
  logic [LW-1:0] list_length;

  // state memory: {count, has_count, evictable, in_list}
  logic          st_we;
  logic [AW-1:0] st_waddr, st_raddr;
  logic [SW-1:0] st_wdata, st_rdata;
  slfu_ram #(.WIDTH(SW), .DEPTH(ENTRIES)) u_state (
    .clk, .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
    .raddr(st_raddr), .rdata(st_rdata));

  // link memories
  logic          nx_we, pv_we;
  logic [AW-1:0] nx_waddr, pv_waddr, nx_wdata, pv_wdata, nx_raddr, pv_raddr;
  logic [AW-1:0] nx_rdata, pv_rdata;
  slfu_ram #(.WIDTH(AW), .DEPTH(ENTRIES)) u_next (
    .clk, .we(nx_we), .waddr(nx_waddr), .wdata(nx_wdata),
    .raddr(nx_raddr), .rdata(nx_rdata));
  slfu_ram #(.WIDTH(AW), .DEPTH(ENTRIES)) u_prev (
    .clk, .we(pv_we), .waddr(pv_waddr), .wdata(pv_wdata),
    .raddr(pv_raddr), .rdata(pv_rdata));

  // group best memory: {entry, count, blocked}
  logic          gb_we;
  logic [GW-1:0] gb_waddr, gb_raddr;
  logic [BW-1:0] gb_wdata, gb_rdata;
  slfu_ram #(.WIDTH(BW), .DEPTH(MAX_VICTIMS)) u_best (
    .clk, .we(gb_we), .waddr(gb_waddr), .wdata(gb_wdata),
    .raddr(gb_raddr), .rdata(gb_rdata));

  // walk state
  logic [AW-1:0] cur;
  logic [NW-1:0] visited, num;
  logic [5:0]    slot;
  logic [RW-1:0] gi, groups, gout;
  logic          gb_blk;
  logic [COUNT_BITS-1:0] gb_cnt;
  logic [AW-1:0] lp, ln;
  logic [5:0]    ss_eff;
  logic [RW-1:0] req_clip;

  // decoded state word
  logic [COUNT_BITS-1:0] s_cnt;
  logic s_has, s_evc, s_in, c_blk;
  assign s_cnt = st_rdata[SW-1:3];
  assign s_has = st_rdata[2];
  assign s_evc = st_rdata[1];
  assign s_in  = st_rdata[0];
  assign c_blk = !s_has || !s_evc;

  assign ss_eff = (samp_size == 6'd0) ? 6'd1 :
                  (samp_size > 6'(slfu_pkg::SAMPLE_MAX)) ? 6'(slfu_pkg::SAMPLE_MAX)
                  : samp_size;
  assign req_clip = (request_count > 8'(MAX_VICTIMS)) ? RW'(MAX_VICTIMS)
                    : RW'(request_count);

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = (state == S_IDLE) || (state == S_CLEAR);

  logic [AW-1:0] clr;
  logic          ob_free;
  logic          ob_load;
  assign ob_free = !out_valid || out_ready;
  assign ob_load = ob_free && (state == S_EOUT || state == S_MARK);

  // memory port steering
  always_comb begin
    st_we = 1'b0; st_waddr = r_ent; st_wdata = '0; st_raddr = r_ent;
    nx_we = 1'b0; nx_waddr = r_ent; nx_wdata = '0; nx_raddr = r_ent;
    pv_we = 1'b0; pv_waddr = r_ent; pv_wdata = '0; pv_raddr = r_ent;
    gb_we = 1'b0; gb_waddr = gi[GW-1:0]; gb_raddr = gout[GW-1:0];
    gb_wdata = {cur, s_cnt, c_blk};
    case (state)
      S_CLEAR: begin
        st_we = 1'b1; st_waddr = clr;
      end
      S_EXEC: begin
        case (r_cmd)
          slfu_pkg::CMD_ADD: begin
            st_we = 1'b1;
            st_wdata = {COUNT_BITS'(1), 1'b1, s_evc, 1'b1};
            if (!s_in) begin
              nx_we = 1'b1; nx_waddr = r_ent; nx_wdata = '0;
              pv_we = 1'b1; pv_waddr = r_ent;
              pv_wdata = (list_length == '0) ? '0 : list_tail;
            end
          end
          slfu_pkg::CMD_ACCESS: begin
            st_we = 1'b1;
            st_wdata = {(!s_has) ? COUNT_BITS'(1) :
                        (s_cnt == CMAX) ? s_cnt : s_cnt + 1'b1,
                        1'b1, s_evc, s_in};
          end
          slfu_pkg::CMD_NOTIFY: begin
            st_we = 1'b1;
            st_wdata = {COUNT_BITS'(0), 1'b0, s_evc, 1'b0};
          end
          slfu_pkg::CMD_FLAGS: begin
            st_we = 1'b1;
            st_wdata = {s_cnt, s_has, r_flag, s_in};
          end
          default: ;
        endcase
      end
      S_NWAIT2: begin
        // link fix-up for an add onto a non-empty list, tail still the old one
        nx_we = 1'b1; nx_waddr = list_tail; nx_wdata = r_ent;
      end
      S_NFIX: begin
        if (head_ptr == r_ent && list_tail == r_ent) begin
        end else if (head_ptr == r_ent) begin
        end else if (list_tail == r_ent) begin
          nx_we = 1'b1; nx_waddr = lp; nx_wdata = '0;
        end else begin
          nx_we = 1'b1; nx_waddr = lp; nx_wdata = ln;
          pv_we = 1'b1; pv_waddr = ln; pv_wdata = lp;
        end
      end
      S_WRD: begin
        st_raddr = cur; nx_raddr = cur;
      end
      S_WCMP: begin
        if (gi < RW'(MAX_VICTIMS) &&
            (slot == 6'd0 || (c_blk != gb_blk ? !c_blk :
                              (!c_blk && s_cnt < gb_cnt))))
          gb_we = 1'b1;
      end
      default: ;
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR; clr <= '0; samp_size <= slfu_pkg::SAMPLE_RESET;
      head_ptr <= '0; list_tail <= '0; list_length <= '0; out_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) samp_size <= cfg_data;
      if (ob_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      case (state)
        S_CLEAR: begin
          clr <= clr + 1'b1;
          if (clr == AW'(ENTRIES - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid) begin
            r_cmd <= cmd; r_ent <= AW'(entry);
            r_flag <= uptodate && on_lru && !dirty && !writeback;
            if (cmd == slfu_pkg::CMD_EVICT) begin
              num <= NW'(req_clip) * NW'(ss_eff);
              cur <= head_ptr; visited <= '0; slot <= '0; gi <= '0;
              state <= (req_clip == '0 || list_length == '0) ? S_MARK : S_WRD;
            end else if (32'(entry) >= ENTRIES || cmd > slfu_pkg::CMD_EVICT ||
                         ((cmd == slfu_pkg::CMD_ADD || cmd == slfu_pkg::CMD_ACCESS)
                          && !relevant)) begin
              state <= S_IDLE;
            end else begin
              state <= S_RD;
            end
          end
        end
        S_RD: state <= (r_cmd == slfu_pkg::CMD_NOTIFY) ? S_NRD : S_EXEC;
        S_NRD: state <= S_EXEC; // link read data now valid too
        S_EXEC: begin
          state <= S_IDLE;
          if (r_cmd == slfu_pkg::CMD_ADD && !s_in) begin
            if (list_length == '0) begin
              head_ptr <= r_ent; list_tail <= r_ent;
            end else begin
              state <= S_NWAIT2;
            end
            list_length <= list_length + 1'b1;
          end
          if (r_cmd == slfu_pkg::CMD_NOTIFY && s_in) begin
            lp <= pv_rdata; ln <= nx_rdata; state <= S_NFIX;
          end
        end
        S_NWAIT2: begin
          list_tail <= r_ent;
          state <= S_IDLE;
        end
        S_NFIX: begin
          if (head_ptr == r_ent && list_tail == r_ent) begin
            head_ptr <= '0; list_tail <= '0;
          end else if (head_ptr == r_ent) begin
            head_ptr <= ln;
          end else if (list_tail == r_ent) begin
            list_tail <= lp;
          end
          if (list_length != '0) list_length <= list_length - 1'b1;
          state <= S_IDLE;
        end
        S_WRD: state <= S_WCMP;
        S_WCMP: begin
          if (gb_we) begin
            gb_cnt <= s_cnt; gb_blk <= c_blk;
          end
          cur <= nx_rdata;
          visited <= visited + 1'b1;
          if (slot + 1'b1 == ss_eff) begin
            slot <= '0; gi <= gi + 1'b1;
          end else begin
            slot <= slot + 1'b1;
          end
          if (visited + 1'b1 < num && (visited + 1'b1) < NW'(list_length)) begin
            state <= S_WRD;
          end else begin
            groups <= gi + 1'b1;
            gout <= '0;
            state <= S_ERD;
          end
        end
        S_ERD: state <= S_EOUT;
        S_EOUT: begin
          if (ob_free) begin
            victim_entry <= 10'(gb_rdata[BW-1 -: AW]);
            blocked <= gb_rdata[0];
            score <= gb_rdata[0] ? '1 : 32'(gb_rdata[COUNT_BITS:1]);
            found <= 1'b1;
            last <= (gout + 1'b1 == groups);
            gout <= gout + 1'b1;
            state <= (gout + 1'b1 == groups) ? S_IDLE : S_ERD;
          end
        end
        S_MARK: begin
          if (ob_free) begin
            victim_entry <= '0; score <= '0;
            blocked <= 1'b0; found <= 1'b0; last <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== tb/sampled_lfu_eviction_picker_test.sv =====
// sampled_lfu_eviction_picker_test: self-checking bench for the lfu eviction picker
// depends on slfu_pkg and the sampled_lfu_eviction_picker rtl
module sampled_lfu_eviction_picker_test;

  localparam int N_ENT = 1024;
  localparam int LIMIT = 3000000;

  typedef struct packed {
    logic [2:0] cmd;
    logic [9:0] entry;
    logic       relevant;
    logic       uptodate;
    logic       on_lru;
    logic       dirty;
    logic       writeback;
    logic [7:0] request_count;
  } request_t;

  typedef struct packed {
    logic [9:0]  victim_entry;
    logic [31:0] score;
    logic        blocked;
    logic        found;
    logic        last;
  } victim_t;

  logic clk = 0, rst = 1;
  logic cfg_valid = 0, cfg_ready;
  logic [5:0] cfg_data = 0;
  logic in_valid = 0, in_ready;
  logic [2:0] cmd = 0;
  logic [9:0] entry = 0;
  logic relevant = 0, uptodate = 0, on_lru = 0, dirty = 0, writeback = 0;
  logic [7:0] request_count = 0;
  logic out_valid, out_ready = 0;
  logic [9:0] victim_entry;
  logic [31:0] score;
  logic blocked, found, last;

  sampled_lfu_eviction_picker uut (.*);

  always #5 clk = ~clk;

  // shadow of the block's state
  logic [31:0] cnt_mem [N_ENT];
  logic        cnt_ok [N_ENT];
  logic        evict_ok [N_ENT];
  logic        listed [N_ENT];
  logic [9:0]  nxt [N_ENT];
  logic [9:0]  prv [N_ENT];
  logic [9:0]  head, tail;
  int          length;
  logic [5:0]  sample_reg;

  request_t pending_requests [$];
  victim_t  expected_victims [$];
  int errors = 0;
  int cycles = 0;
  bit hold_sender = 0;
  logic in_acc = 0;

  task automatic shadow_reset();
    for (int i = 0; i < N_ENT; i++) begin
      cnt_mem[i] = 0; cnt_ok[i] = 0; evict_ok[i] = 0; listed[i] = 0;
      nxt[i] = 0; prv[i] = 0;
    end
    head = 0; tail = 0; length = 0; sample_reg = slfu_pkg::SAMPLE_RESET;
  endtask

  // evict walk: one victim per sampled group
  task automatic pick_victims(input logic [7:0] rc);
    int req, ss, num, visited, groups;
    logic [9:0] cur;
    logic [9:0] b_ent [slfu_pkg::SAMPLE_MAX];
    logic [31:0] b_cnt [slfu_pkg::SAMPLE_MAX];
    logic b_blk [slfu_pkg::SAMPLE_MAX];
    logic blk;
    bit take;
    victim_t v;
    req = rc > 32 ? 32 : rc;
    ss = sample_reg == 0 ? 1 :
         (sample_reg > slfu_pkg::SAMPLE_MAX ? slfu_pkg::SAMPLE_MAX : sample_reg);
    num = req * ss;
    visited = 0;
    cur = head;
    while (visited < num && visited < length) begin
      blk = !cnt_ok[cur] || !evict_ok[cur];
      if (visited % ss == 0) take = 1;
      else if (blk != b_blk[visited / ss]) take = !blk;
      else take = !blk && cnt_mem[cur] < b_cnt[visited / ss];
      if (take) begin
        b_ent[visited / ss] = cur; b_cnt[visited / ss] = cnt_mem[cur];
        b_blk[visited / ss] = blk;
      end
      visited++;
      cur = nxt[cur];
    end
    groups = (visited + ss - 1) / ss;
    if (groups > req) groups = req;
    if (groups == 0) begin
      v = '{victim_entry: 0, score: 0, blocked: 0, found: 0, last: 1};
      expected_victims.push_back(v);
    end
    for (int g = 0; g < groups; g++) begin
      v.victim_entry = b_ent[g];
      v.score = b_blk[g] ? 32'hFFFF_FFFF : b_cnt[g];
      v.blocked = b_blk[g];
      v.found = 1;
      v.last = (g + 1 == groups);
      expected_victims.push_back(v);
    end
  endtask

  // apply one accepted request to the shadow state
  task automatic apply_request(input request_t r);
    logic [9:0] e, p, n;
    e = r.entry;
    case (r.cmd)
      slfu_pkg::CMD_ADD: if (r.relevant) begin
        if (!listed[e]) begin
          if (length == 0) begin
            head = e; prv[e] = 0;
          end else begin
            nxt[tail] = e; prv[e] = tail;
          end
          nxt[e] = 0; tail = e; listed[e] = 1; length++;
        end
        cnt_mem[e] = 1; cnt_ok[e] = 1;
      end
      slfu_pkg::CMD_ACCESS: if (r.relevant) begin
        if (!cnt_ok[e]) begin
          cnt_ok[e] = 1; cnt_mem[e] = 0;
        end
        if (cnt_mem[e] != 32'hFFFF_FFFF) cnt_mem[e]++;
      end
      slfu_pkg::CMD_NOTIFY: begin
        cnt_ok[e] = 0; cnt_mem[e] = 0;
        if (listed[e]) begin
          p = prv[e]; n = nxt[e];
          if (head == e && tail == e) begin
            head = 0; tail = 0;
          end else if (head == e) head = n;
          else if (tail == e) begin
            tail = p; nxt[p] = 0;
          end else begin
            nxt[p] = n; prv[n] = p;
          end
          listed[e] = 0;
          if (length > 0) length--;
        end
      end
      slfu_pkg::CMD_FLAGS:
        evict_ok[e] = r.uptodate && r.on_lru && !r.dirty && !r.writeback;
      slfu_pkg::CMD_EVICT: pick_victims(r.request_count);
      default: ;
    endcase
  endtask

  // request acceptance seen at the rising edge
  always @(posedge clk) in_acc <= !rst && in_valid && in_ready;

  // driver: bursts and gaps, payload held until accepted
  int gap = 0, burst = 0;
  always @(negedge clk) begin
    request_t r;
    if (!rst) begin
      if (in_acc) begin
        apply_request(pending_requests.pop_front());
      end
      if (!in_valid || in_acc) begin
        if (gap > 0) gap--;
        if (hold_sender || pending_requests.size() == 0 || gap > 0) begin
          in_valid <= 0;
        end else begin
          r = pending_requests[0];
          {cmd, entry, relevant, uptodate, on_lru, dirty, writeback, request_count} <= r;
          in_valid <= 1;
          if (burst == 0) begin
            burst = $urandom_range(1, 20);
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
          end else burst--;
        end
      end
      out_ready <= ($urandom_range(0, 3) != 0) || (cycles / 2000) % 3 == 0;
    end
  end

  // monitor: compare each result with the oldest expectation
  always @(posedge clk) begin
    victim_t got, want;
    cycles++;
    if (!rst && out_valid && out_ready) begin
      got = {victim_entry, score, blocked, found, last};
      if (expected_victims.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
      end else begin
        want = expected_victims.pop_front();
        if (got.victim_entry !== want.victim_entry) begin
          $display("%0t: victim_entry exp %0d got %0d", $time, want.victim_entry,
                   got.victim_entry); errors++;
        end
        if (got.score !== want.score) begin
          $display("%0t: score exp %h got %h", $time, want.score, got.score); errors++;
        end
        if (got.blocked !== want.blocked) begin
          $display("%0t: blocked exp %b got %b", $time, want.blocked, got.blocked); errors++;
        end
        if (got.found !== want.found) begin
          $display("%0t: found exp %b got %b", $time, want.found, got.found); errors++;
        end
        if (got.last !== want.last) begin
          $display("%0t: last exp %b got %b", $time, want.last, got.last); errors++;
        end
      end
    end
    if (cycles > LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic request_t mk(input logic [2:0] c, input int e, input bit rel = 1,
                                  input logic [3:0] fl = 4'b1100, input int rc = 0);
    request_t r;
    r.cmd = c; r.entry = 10'(e); r.relevant = rel;
    {r.uptodate, r.on_lru, r.dirty, r.writeback} = fl;
    r.request_count = 8'(rc);
    return r;
  endfunction

  // wait for drain, plus the tail latency of commands with no result
  task automatic drain();
    while (pending_requests.size() != 0 || in_valid || expected_victims.size() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_sample(input logic [5:0] v);
    @(negedge clk);
    cfg_data <= v; cfg_valid <= 1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sample_reg = v;
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  // one phase of random traffic, mostly over a small pool of entries
  task automatic random_phase(input int n);
    int pool, e, k;
    for (int i = 0; i < n; i++) begin
      pool = $urandom_range(0, 7) == 0 ? 1024 : 48;
      e = $urandom_range(0, pool - 1);
      k = $urandom_range(0, 19);
      if (k < 6)
        pending_requests.push_back(mk(slfu_pkg::CMD_ADD, e, $urandom_range(0, 7) != 0));
      else if (k < 10)
        pending_requests.push_back(mk(slfu_pkg::CMD_ACCESS, e, $urandom_range(0, 7) != 0));
      else if (k < 12)
        pending_requests.push_back(mk(slfu_pkg::CMD_NOTIFY, e, 1'($urandom_range(0, 1))));
      else if (k < 16)
        pending_requests.push_back(mk(slfu_pkg::CMD_FLAGS, e, 1'($urandom_range(0, 1)),
            $urandom_range(0, 2) == 0 ? 4'($urandom_range(0, 15)) : 4'b1100));
      else if (k < 19)
        pending_requests.push_back(mk(slfu_pkg::CMD_EVICT, $urandom_range(0, 1023),
            1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)),
            $urandom_range(0, 5) == 0 ? $urandom_range(0, 255) : $urandom_range(0, 4)));
      else
        pending_requests.push_back(mk(3'($urandom_range(5, 7)), e, 1'($urandom_range(0, 1)),
            4'($urandom_range(0, 15)), $urandom_range(0, 255)));
    end
  endtask

  initial begin
    shadow_reset();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    // directed: empty walk, adds, flags, re-add, access, unlink, extremes
    pending_requests.push_back(mk(slfu_pkg::CMD_EVICT, 1023, 1, 4'b0000, 5));
    pending_requests.push_back(mk(slfu_pkg::CMD_ADD, 0));
    pending_requests.push_back(mk(slfu_pkg::CMD_ADD, 1023));
    pending_requests.push_back(mk(slfu_pkg::CMD_ADD, 5));
    pending_requests.push_back(mk(slfu_pkg::CMD_ADD, 7, 0));
    pending_requests.push_back(mk(slfu_pkg::CMD_FLAGS, 1023, 0, 4'b1100));
    pending_requests.push_back(mk(slfu_pkg::CMD_FLAGS, 5, 1, 4'b1110));
    pending_requests.push_back(mk(slfu_pkg::CMD_FLAGS, 0, 1, 4'b1101));
    pending_requests.push_back(mk(slfu_pkg::CMD_ACCESS, 1023));
    pending_requests.push_back(mk(slfu_pkg::CMD_ACCESS, 9));
    pending_requests.push_back(mk(slfu_pkg::CMD_ADD, 1023));
    pending_requests.push_back(mk(slfu_pkg::CMD_EVICT, 0, 0, 4'b1111, 0));
    pending_requests.push_back(mk(slfu_pkg::CMD_EVICT, 0, 0, 4'b0000, 255));
    pending_requests.push_back(mk(slfu_pkg::CMD_NOTIFY, 9));
    pending_requests.push_back(mk(slfu_pkg::CMD_NOTIFY, 5));
    pending_requests.push_back(mk(3'd7, 3, 1, 4'b1111, 8'hFF));
    pending_requests.push_back(mk(slfu_pkg::CMD_NOTIFY, 1023));
    pending_requests.push_back(mk(slfu_pkg::CMD_EVICT, 0, 0, 4'b0000, 1));
    pending_requests.push_back(mk(slfu_pkg::CMD_NOTIFY, 0));
    pending_requests.push_back(mk(slfu_pkg::CMD_EVICT, 0, 0, 4'b0000, 3));
    drain();
    // phases over several sample sizes, extremes and out-of-range included
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: write_sample(6'd1);
        1: write_sample(6'd32);
        2: write_sample(6'd3);
        3: write_sample(6'd0);
        4: write_sample(6'd63);
        default: write_sample(6'd5);
      endcase
      random_phase(25);
      // in phase 2, let everything settle before carrying on
      if (ph == 2) begin
        hold_sender = 1;
        while (expected_victims.size() != 0 || in_valid) @(posedge clk);
        hold_sender = 0;
      end
      random_phase(25);
      drain();
    end
    if (errors == 0 && expected_victims.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
design/slfu_pkg.sv
design/slfu_ram.sv
design/sampled_lfu_eviction_picker.sv
tb/sampled_lfu_eviction_picker_test.sv
